// ----- sv/selectable_crc_codeword_generator_unit_defines.svh -----
// Assertion macros shared by the checker files of the CRC codeword generator.
// Depends on nothing; included by bare file name.
`ifndef SELECTABLE_CRC_CODEWORD_GENERATOR_UNIT_DEFINES_SVH
`define SELECTABLE_CRC_CODEWORD_GENERATOR_UNIT_DEFINES_SVH

// Implication checked only while out of reset.
`define CRCGEN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crcgen: implication check failed");

// Implication checked at every edge, reset included.
`define CRCGEN_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("crcgen: reset-state check failed");

`endif

// ----- sv/crcgen_pkg.sv -----
// Shared types, constants and the remainder update of the CRC codeword generator.
// Depends on nothing.
package crcgen_pkg;

    localparam int REM_W      = 16;
    localparam int TAIL_CNT_W = 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] SEL_CRC12 = 2'd0;
    localparam logic [1:0] SEL_CRC16 = 2'd1;

    localparam logic [REM_W-1:0] CRC12_POLY = 16'h080F;
    localparam logic [REM_W-1:0] CRC16_POLY = 16'h8005;
    localparam logic [REM_W-1:0] CCITT_POLY = 16'h1021;
    localparam logic [REM_W-1:0] CRC12_MASK = 16'h0FFF;

    localparam logic [TAIL_CNT_W-1:0] CRC12_W = 5'd12;
    localparam logic [TAIL_CNT_W-1:0] CRC16_W = 5'd16;

    typedef struct packed {
        logic             data_bit;
        logic             last;
        logic             wide;
        logic [REM_W-1:0] rem;
    } crc_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } crc_q_status_t;

    function automatic logic [REM_W-1:0] crc_step(
        input logic [REM_W-1:0] rem,
        input logic [1:0]       sel,
        input logic             din
    );
        logic [REM_W-1:0] r;
        logic             fb;
        priority if (sel == SEL_CRC12)
        begin
            fb = rem[11] ^ din;
            r  = {rem[REM_W-2:0], 1'b0} & CRC12_MASK;
            if (fb)
            begin
                r = r ^ CRC12_POLY;
            end
        end
        else if (sel == SEL_CRC16)
        begin
            fb = rem[REM_W-1] ^ din;
            r  = {rem[REM_W-2:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC16_POLY;
            end
        end
        else
        begin
            fb = rem[REM_W-1] ^ din;
            r  = {rem[REM_W-2:0], 1'b0};
            if (fb)
            begin
                r = r ^ CCITT_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/crcgen_front.sv -----
// Front end: accepts message bits, keeps the running remainder and the generator choice.
// Depends on crcgen_pkg.
module crcgen_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   data_bit,
    input  logic                   last_in,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_wr_data,
    input  crcgen_pkg::crc_q_status_t q_status,
    output logic                   full,
    output logic                   q_push,
    output crcgen_pkg::crc_item_t  q_item
);

    logic [1:0]                   poly_sel_reg;
    logic [crcgen_pkg::REM_W-1:0] rem_reg;
    logic [crcgen_pkg::REM_W-1:0] rem_step;
    logic [crcgen_pkg::REM_W-1:0] rem_next;

    assign full     = q_status.full;
    assign q_push   = push && !q_status.full;
    assign rem_step = crcgen_pkg::crc_step(rem_reg, poly_sel_reg, data_bit);
    assign rem_next = last_in ? '0 : rem_step;

    assign q_item.data_bit = data_bit;
    assign q_item.last     = last_in;
    assign q_item.wide     = (poly_sel_reg != crcgen_pkg::SEL_CRC12);
    assign q_item.rem      = rem_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_sel_reg <= crcgen_pkg::SEL_CRC12;
            rem_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                poly_sel_reg <= cfg_wr_data;
            end
            if (q_push)
            begin
                rem_reg <= rem_next;
            end
        end
    end

endmodule

// ----- sv/crcgen_fifo.sv -----
// Short item queue between the front end and the serialiser.
// Depends on crcgen_pkg.
module crcgen_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  crcgen_pkg::crc_item_t     wr_item,
    input  logic                      rd_en,
    output crcgen_pkg::crc_item_t     rd_item,
    output crcgen_pkg::crc_q_status_t status
);

    crcgen_pkg::crc_item_t              mem [crcgen_pkg::Q_DEPTH];
    logic [crcgen_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [crcgen_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [crcgen_pkg::Q_CNT_W-1:0]     count_reg;
    logic [crcgen_pkg::Q_CNT_W-1:0]     count_next;
    logic                               do_wr;
    logic                               do_rd;

    localparam logic [crcgen_pkg::Q_PTR_W-1:0] PtrLast =
        crcgen_pkg::Q_PTR_W'(crcgen_pkg::Q_DEPTH - 1);
    localparam logic [crcgen_pkg::Q_CNT_W-1:0] CntFull =
        crcgen_pkg::Q_CNT_W'(crcgen_pkg::Q_DEPTH);

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CntFull);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_item      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ----- sv/crcgen_back.sv -----
// Back end: echoes each queued bit and shifts out the remainder tail into an output register.
// Depends on crcgen_pkg.
module crcgen_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  crcgen_pkg::crc_q_status_t q_status,
    input  crcgen_pkg::crc_item_t     q_item,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic                      code_bit,
    output logic                      last_out
);

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_bit_reg;
    logic                              out_bit_next;
    logic                              out_last_reg;
    logic                              out_last_next;
    logic [crcgen_pkg::TAIL_CNT_W-1:0] tail_cnt_reg;
    logic [crcgen_pkg::TAIL_CNT_W-1:0] tail_cnt_next;
    logic [crcgen_pkg::REM_W-1:0]      tail_sr_reg;
    logic [crcgen_pkg::REM_W-1:0]      tail_sr_next;
    logic                              out_free;

    assign empty    = !out_valid_reg;
    assign code_bit = out_bit_reg;
    assign last_out = out_last_reg;
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        tail_cnt_next  = tail_cnt_reg;
        tail_sr_next   = tail_sr_reg;
        q_pop          = 1'b0;
        if (out_free)
        begin
            priority if (tail_cnt_reg != '0)
            begin
                out_valid_next = 1'b1;
                out_bit_next   = tail_sr_reg[crcgen_pkg::REM_W-1];
                out_last_next  = (tail_cnt_reg == crcgen_pkg::TAIL_CNT_W'(1));
                tail_sr_next   = {tail_sr_reg[crcgen_pkg::REM_W-2:0], 1'b0};
                tail_cnt_next  = tail_cnt_reg - 1'b1;
            end
            else if (!q_status.empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                out_bit_next   = q_item.data_bit;
                out_last_next  = 1'b0;
                if (q_item.last)
                begin
                    tail_sr_next  = q_item.wide ? q_item.rem : {q_item.rem[11:0], 4'b0000};
                    tail_cnt_next = q_item.wide ? crcgen_pkg::CRC16_W : crcgen_pkg::CRC12_W;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
        tail_sr_reg  <= tail_sr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tail_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tail_cnt_reg  <= tail_cnt_next;
        end
    end

endmodule

// ----- sv/selectable_crc_codeword_generator_unit.sv -----
// Top level of the selectable bit-serial CRC codeword generator.
// Depends on crcgen_pkg, crcgen_front, crcgen_fifo and crcgen_back.
//
// Input channel: push/full with data_bit and last_in, one message bit per item,
// most significant first. Output channel: empty/pop with code_bit and last_out.
// Each message bit is echoed; after the bit marked last the block appends the
// 12 or 16 remainder bits (most significant first) and raises last_out on the
// final one. cfg_wr_en/cfg_wr_data pick the generator: 0 CRC-12, 1 CRC-16,
// 2 or 3 CRC-CCITT; write only while the block is idle.
// An accepted item is written into the queue and then moved into the output register.
// Throughput: one bit per cycle while the output is popped every cycle; after the
// last bit of a message the serialiser shifts out the remainder one bit per cycle
// and takes no new item meanwhile, so the two-entry queue in front of it can fill
// and assert full until the tail drains.
// Reset clears the remainder, the queue and the output register and selects CRC-12.
// When pop is low the waiting result holds; the queue fills and full rises.
module selectable_crc_codeword_generator_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       data_bit,
    input  logic       last_in,
    output logic       empty,
    input  logic       pop,
    output logic       code_bit,
    output logic       last_out,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    crcgen_pkg::crc_q_status_t q_status;
    crcgen_pkg::crc_item_t     q_wr_item;
    crcgen_pkg::crc_item_t     q_rd_item;
    logic                      q_push;
    logic                      q_pop;

    crcgen_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_bit    (data_bit),
        .last_in     (last_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .full        (full),
        .q_push      (q_push),
        .q_item      (q_wr_item)
    );

    crcgen_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .status  (q_status)
    );

    crcgen_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .code_bit (code_bit),
        .last_out (last_out)
    );

endmodule

// ----- sv/crcgen_checker.sv -----
// Port-level checks for the CRC codeword generator, bound to the top level.
// Depends on selectable_crc_codeword_generator_unit_defines.svh.
`include "selectable_crc_codeword_generator_unit_defines.svh"

module crcgen_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic code_bit,
    input logic last_out
);

    `CRCGEN_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, empty && !full)
    `CRCGEN_ASSERT_IMPL(a_stall_hold, clk, rst_n, !empty && !pop, ##1 (!empty && $stable(code_bit) && $stable(last_out)))
    `CRCGEN_ASSERT_IMPL(a_accept_shows, clk, rst_n, push && !full, ##2 !empty)

endmodule

bind selectable_crc_codeword_generator_unit crcgen_checker u_crcgen_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .code_bit (code_bit),
    .last_out (last_out)
);

// ----- bench/tb_selectable_crc_codeword_generator_unit.sv -----
// Self-checking bench for the selectable bit-serial CRC codeword generator.
// Predicts every codeword bit from its own CRC remainder model and checks the output in order.
// Depends on crcgen_pkg and selectable_crc_codeword_generator_unit.
module tb_selectable_crc_codeword_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] SEL_CCITT     = 2'd2;
    localparam logic [1:0] SEL_CCITT_ALT = 2'd3;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         LONG_HOLD     = 400;
    localparam int         ITEM_TARGET   = 470;
    localparam int         FILL_LEN      = 24;

    typedef struct packed {
        logic data_bit;
        logic last;
    } msg_bit_t;

    typedef struct packed {
        logic code_bit;
        logic last_out;
    } code_bit_t;

    logic       clk         = 1'b0;
    logic       rst_n;
    logic       push        = 1'b0;
    logic       full;
    logic       data_bit    = 1'b0;
    logic       last_in     = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic       code_bit;
    logic       last_out;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    msg_bit_t    msg_q[$];
    code_bit_t   codeword_q[$];
    logic [15:0] crc_rem;
    logic [1:0]  crc_sel;
    int          errors        = 0;
    int          items_sent    = 0;
    bit          took_bit      = 1'b0;
    bit          long_hold_req = 1'b0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          hold_left     = 0;
    int unsigned rx_cycle      = 0;

    selectable_crc_codeword_generator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_bit    (data_bit),
        .last_in     (last_in),
        .empty       (empty),
        .pop         (pop),
        .code_bit    (code_bit),
        .last_out    (last_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    task automatic note_mismatch(input string what);
        errors++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    function automatic void crc_advance(input logic din, input logic lst);
        int unsigned w;
        logic [15:0] p;
        logic [15:0] m;
        logic [15:0] r;
        logic        fb;
        code_bit_t   c;
        if (crc_sel == crcgen_pkg::SEL_CRC12)
        begin
            w = 12;
            p = crcgen_pkg::CRC12_POLY;
        end
        else if (crc_sel == crcgen_pkg::SEL_CRC16)
        begin
            w = 16;
            p = crcgen_pkg::CRC16_POLY;
        end
        else
        begin
            w = 16;
            p = crcgen_pkg::CCITT_POLY;
        end
        m  = (w == 12) ? 16'h0FFF : 16'hFFFF;
        r  = crc_rem & m;
        fb = r[w-1] ^ din;
        r  = (r << 1) & m;
        if (fb)
        begin
            r = r ^ p;
        end
        c.code_bit = din;
        c.last_out = 1'b0;
        codeword_q.push_back(c);
        if (lst)
        begin
            for (int k = 0; k < w; k++)
            begin
                c.code_bit = r[w-1-k];
                c.last_out = (k == w - 1);
                codeword_q.push_back(c);
            end
            r = '0;
        end
        crc_rem = r;
    endfunction

    // predictor and output check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_rem  = '0;
            crc_sel  = crcgen_pkg::SEL_CRC12;
            took_bit = 1'b0;
            codeword_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                crc_sel = cfg_wr_data;
            end
            took_bit = push && !full;
            if (took_bit)
            begin
                crc_advance(data_bit, last_in);
            end
            if (pop && !empty)
            begin
                if (codeword_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected item code_bit=%b last_out=%b",
                                            code_bit, last_out));
                end
                else
                begin
                    code_bit_t e;
                    e = codeword_q.pop_front();
                    if (code_bit !== e.code_bit)
                    begin
                        note_mismatch($sformatf("code_bit %b, expected %b",
                                                code_bit, e.code_bit));
                    end
                    if (last_out !== e.last_out)
                    begin
                        note_mismatch($sformatf("last_out %b, expected %b",
                                                last_out, e.last_out));
                    end
                end
            end
        end
    end

    // sender: bursts of items with gaps between them
    always @(negedge clk)
    begin
        if (rst_n && (!push || took_bit))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (msg_q.size() > 0)
            begin
                msg_bit_t b;
                b = msg_q.pop_front();
                push     <= 1'b1;
                data_bit <= b.data_bit;
                last_in  <= b.last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, plus one long hold on request
    always @(negedge clk)
    begin
        rx_cycle++;
        if (long_hold_req)
        begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 128) % 4)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((rx_cycle % 8) < 5);
            endcase
        end
    end

    task automatic add_bit(input logic d, input logic lst);
        msg_bit_t b;
        b.data_bit = d;
        b.last     = lst;
        msg_q.push_back(b);
        items_sent++;
    endtask

    task automatic wait_idle();
        while (msg_q.size() != 0 || push || codeword_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_sel(input logic [1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        #20_000_000;
        $display("selectable_crc_codeword_generator_unit regression: fail");
        $finish;
    end

    initial
    begin
        int          phase;
        int          msgs;
        int          len;
        bit          open_end;
        rst_n <= 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_bit(1'b1, 1'b1);
        add_bit(1'b0, 1'b1);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b0);
        add_bit(1'b1, 1'b1);
        wait_idle();
        write_sel(crcgen_pkg::SEL_CRC16);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b1);
        add_bit(1'b1, 1'b1);
        wait_idle();
        write_sel(SEL_CCITT);
        add_bit(1'b1, 1'b1);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        wait_idle();
        write_sel(crcgen_pkg::SEL_CRC12);
        add_bit(1'b1, 1'b1);
        wait_idle();
        write_sel(SEL_CCITT_ALT);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b1);
        add_bit(1'b0, 1'b1);
        wait_idle();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            write_sel(2'($urandom_range(0, 3)));
            msgs = $urandom_range(1, 6);
            for (int i = 0; i < msgs; i++)
            begin
                len      = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                       : $urandom_range(1, 16);
                open_end = (i == msgs - 1) && ($urandom_range(0, 3) == 0);
                for (int j = 0; j < len; j++)
                begin
                    add_bit(1'($urandom_range(0, 1)), (j == len - 1) && !open_end);
                end
            end
            if (phase == 2)
            begin
                for (int j = 0; j < FILL_LEN; j++)
                begin
                    add_bit(1'($urandom_range(0, 1)), j == FILL_LEN - 1);
                end
                long_hold_req = 1'b1;
            end
            wait_idle();
            phase++;
        end

        if (errors == 0 && codeword_q.size() == 0)
        begin
            $display("selectable_crc_codeword_generator_unit regression: pass");
        end
        else
        begin
            $display("selectable_crc_codeword_generator_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/crcgen_pkg.sv
sv/crcgen_front.sv
sv/crcgen_fifo.sv
sv/crcgen_back.sv
sv/selectable_crc_codeword_generator_unit.sv
sv/crcgen_checker.sv
bench/tb_selectable_crc_codeword_generator_unit.sv
